// ===== hdl/tms_pkg.sv =====
`default_nettype none

package tms_pkg;

	localparam int MODE_W      = 2;
	localparam int TEMP_W      = 10;
	localparam int DELAY_W     = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [MODE_W-1:0] MODE_STOP = 2'd0;
	localparam logic [MODE_W-1:0] MODE_COOL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HEAT = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

	localparam logic [CFG_INDEX_W-1:0] CFG_STOP_FAN_DELAY    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_START_DELAY       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_FAULT_DELAY       = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_HEAT_STOP_LEVEL   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_HEAT_START_LEVEL  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_FALLBACK_OFF_TIME = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_FALLBACK_ON_TIME  = 3'd6;

	localparam logic [TEMP_W-1:0] TEMP_FAULT_LOW  = 10'd0;
	localparam logic [TEMP_W-1:0] TEMP_FAULT_HIGH = 10'd1023;

	localparam logic [DELAY_W-1:0] RST_STOP_FAN_DELAY    = 16'd10000;
	localparam logic [DELAY_W-1:0] RST_START_DELAY       = 16'd3000;
	localparam logic [DELAY_W-1:0] RST_FAULT_DELAY       = 16'd5000;
	localparam logic [TEMP_W-1:0]  RST_HEAT_STOP_LEVEL   = 10'd400;
	localparam logic [TEMP_W-1:0]  RST_HEAT_START_LEVEL  = 10'd600;
	localparam logic [DELAY_W-1:0] RST_FALLBACK_OFF_TIME = 16'd4000;
	localparam logic [DELAY_W-1:0] RST_FALLBACK_ON_TIME  = 16'd10000;

	typedef logic [MODE_W-1:0] mode_t;
	typedef logic [TEMP_W-1:0] temp_t;
	typedef logic [DELAY_W-1:0] delay_t;

endpackage

`default_nettype wire

// ===== hdl/tms_tick_if.sv =====
`default_nettype none

interface tms_tick_if;
	import tms_pkg::*;

	logic  valid;
	logic  ready;
	mode_t requested_mode;
	temp_t temperature;

	modport source (output valid, output requested_mode, output temperature, input ready);
	modport sink (input valid, input requested_mode, input temperature, output ready);
endinterface

`default_nettype wire

// ===== hdl/tms_relay_if.sv =====
`default_nettype none

interface tms_relay_if;
	logic valid;
	logic ready;
	logic cool_drive;
	logic heat_drive;
	logic fan_drive;
	logic sensor_fault;
	logic fallback_active;

	modport source (output valid, output cool_drive, output heat_drive, output fan_drive,
		output sensor_fault, output fallback_active, input ready);
	modport sink (input valid, input cool_drive, input heat_drive, input fan_drive,
		input sensor_fault, input fallback_active, output ready);
endinterface

`default_nettype wire

// ===== hdl/thermoelectric_mode_sequencer.sv =====
// Channel   Direction  Payload
// tick      in         requested_mode[1:0], temperature[9:0]
// relay     out        cool_drive, heat_drive, fan_drive, sensor_fault, fallback_active
// cfg_*     in         write enable, register index[2:0], data[15:0]
//
// One tick is taken per clock cycle unless stalled; results pass input and result registers.
// The sequencer state is updated as a tick moves from the input register to the result register.
// A stalled result register holds, and the input register still takes a tick while it is empty.
// Reset loads the register defaults, enters no mode and opens no relay.
`default_nettype none

module thermoelectric_mode_sequencer #(
	parameter int TIMER_BITS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	tms_tick_if.sink                              tick,
	tms_relay_if.source                           relay,
	input  wire logic                             cfg_we,
	input  wire logic [tms_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [tms_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import tms_pkg::*;

	localparam int CMP_W = (TIMER_BITS > DELAY_W) ? TIMER_BITS : DELAY_W;

	typedef logic [TIMER_BITS-1:0] timer_t;

	function automatic logic expired(timer_t t, delay_t d);
		return CMP_W'(t) >= CMP_W'(d);
	endfunction

	function automatic timer_t tick_up(timer_t t);
		return (t == {TIMER_BITS{1'b1}}) ? t : t + 1'b1;
	endfunction

	delay_t stop_fan_delay_q, start_delay_q, fault_delay_q;
	delay_t fallback_off_time_q, fallback_on_time_q;
	temp_t  heat_stop_level_q, heat_start_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_fan_delay_q    <= RST_STOP_FAN_DELAY;
			start_delay_q       <= RST_START_DELAY;
			fault_delay_q       <= RST_FAULT_DELAY;
			heat_stop_level_q   <= RST_HEAT_STOP_LEVEL;
			heat_start_level_q  <= RST_HEAT_START_LEVEL;
			fallback_off_time_q <= RST_FALLBACK_OFF_TIME;
			fallback_on_time_q  <= RST_FALLBACK_ON_TIME;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STOP_FAN_DELAY:    stop_fan_delay_q    <= cfg_data;
				CFG_START_DELAY:       start_delay_q       <= cfg_data;
				CFG_FAULT_DELAY:       fault_delay_q       <= cfg_data;
				CFG_HEAT_STOP_LEVEL:   heat_stop_level_q   <= cfg_data[TEMP_W-1:0];
				CFG_HEAT_START_LEVEL:  heat_start_level_q  <= cfg_data[TEMP_W-1:0];
				CFG_FALLBACK_OFF_TIME: fallback_off_time_q <= cfg_data;
				CFG_FALLBACK_ON_TIME:  fallback_on_time_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	logic  valid_s1;
	mode_t mode_s1;
	temp_t temp_s1;

	// Result register
	logic valid_s2;
	logic cool_s2, heat_s2, fan_s2, fault_s2, fb_s2;

	logic advance_s2;
	logic process;

	assign advance_s2 = !valid_s2 || relay.ready;
	assign process    = valid_s1 && advance_s2;
	assign tick.ready = !valid_s1 || advance_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			mode_s1 <= tick.requested_mode;
			temp_s1 <= tick.temperature;
		end
	end

	// Sequencer state
	mode_t  cur_mode_q;
	timer_t mode_elapsed_q, fault_elapsed_q, fb_elapsed_q;
	logic   fault_q, fb_phase_q, fb_armed_q;
	logic   cool_q, heat_q, fan_q;

	mode_t  cur_mode_d;
	timer_t mode_elapsed_d, fault_elapsed_d, fb_elapsed_d;
	logic   fault_d, fb_phase_d, fb_armed_d;
	logic   cool_d, heat_d, fan_d, fb_d;
	logic   bad_reading;

	assign bad_reading = (temp_s1 == TEMP_FAULT_LOW) || (temp_s1 == TEMP_FAULT_HIGH);

	always_comb begin
		cur_mode_d      = cur_mode_q;
		mode_elapsed_d  = tick_up(mode_elapsed_q);
		fault_elapsed_d = tick_up(fault_elapsed_q);
		fb_elapsed_d    = tick_up(fb_elapsed_q);
		fault_d         = fault_q;
		fb_phase_d      = fb_phase_q;
		fb_armed_d      = fb_armed_q;
		cool_d          = cool_q;
		heat_d          = heat_q;
		fan_d           = fan_q;
		fb_d            = 1'b0;
		unique case (mode_s1)
			MODE_STOP: begin
				fault_d = 1'b0;
				cool_d  = 1'b0;
				heat_d  = 1'b0;
				if (cur_mode_q != MODE_STOP) begin
					cur_mode_d     = MODE_STOP;
					mode_elapsed_d = '0;
				end
				if (expired(mode_elapsed_d, stop_fan_delay_q)) begin
					fan_d = 1'b0;
				end
			end
			MODE_COOL: begin
				fault_d = 1'b0;
				fan_d   = 1'b1;
				if (cur_mode_q != MODE_COOL) begin
					cur_mode_d     = MODE_COOL;
					mode_elapsed_d = '0;
					cool_d         = 1'b0;
					heat_d         = 1'b0;
				end
				if (expired(mode_elapsed_d, start_delay_q)) begin
					cool_d = 1'b1;
					heat_d = 1'b1;
				end
			end
			MODE_HEAT: begin
				fan_d = 1'b1;
				if (cur_mode_q != MODE_HEAT) begin
					cur_mode_d     = MODE_HEAT;
					mode_elapsed_d = '0;
					cool_d         = 1'b0;
					heat_d         = 1'b0;
				end
				if (expired(mode_elapsed_d, start_delay_q)) begin
					if (bad_reading && !fault_q) begin
						fault_d         = 1'b1;
						fault_elapsed_d = '0;
					end
					if (fault_d && expired(fault_elapsed_d, fault_delay_q)) begin
						// The duty cycle replaces the thermostat.
						fb_d = 1'b1;
						if (!fb_armed_q) begin
							fb_armed_d   = 1'b1;
							fb_elapsed_d = '0;
						end
						if (expired(fb_elapsed_d,
							fb_phase_q ? fallback_on_time_q : fallback_off_time_q)) begin
							cool_d     = fb_phase_q;
							fb_phase_d = !fb_phase_q;
							fb_armed_d = 1'b0;
						end
					end else if (temp_s1 < heat_stop_level_q) begin
						cool_d = 1'b0;
					end else if (temp_s1 > heat_start_level_q) begin
						cool_d = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode_q      <= MODE_NONE;
			mode_elapsed_q  <= '0;
			fault_elapsed_q <= '0;
			fb_elapsed_q    <= '0;
			fault_q         <= 1'b0;
			fb_phase_q      <= 1'b0;
			fb_armed_q      <= 1'b0;
			cool_q          <= 1'b0;
			heat_q          <= 1'b0;
			fan_q           <= 1'b0;
		end else if (process) begin
			cur_mode_q      <= cur_mode_d;
			mode_elapsed_q  <= mode_elapsed_d;
			fault_elapsed_q <= fault_elapsed_d;
			fb_elapsed_q    <= fb_elapsed_d;
			fault_q         <= fault_d;
			fb_phase_q      <= fb_phase_d;
			fb_armed_q      <= fb_armed_d;
			cool_q          <= cool_d;
			heat_q          <= heat_d;
			fan_q           <= fan_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			cool_s2  <= cool_d;
			heat_s2  <= heat_d;
			fan_s2   <= fan_d;
			fault_s2 <= fault_d;
			fb_s2    <= fb_d;
		end
	end

	assign relay.valid           = valid_s2;
	assign relay.cool_drive      = cool_s2;
	assign relay.heat_drive      = heat_s2;
	assign relay.fan_drive       = fan_s2;
	assign relay.sensor_fault    = fault_s2;
	assign relay.fallback_active = fb_s2;

	// The fallback cycle only runs in heat mode with a latched fault.
	a_fallback_in_heat: assert property (@(posedge clk) disable iff (!arst_n)
		(relay.valid && relay.fallback_active) |->
			(relay.sensor_fault && relay.fan_drive && !relay.heat_drive))
		else $error("fallback result outside heat mode with a latched fault");

	// A valid mode request is always entered.
	a_mode_entered: assert property (@(posedge clk) disable iff (!arst_n)
		(process && (mode_s1 != MODE_NONE)) |=> (cur_mode_q == $past(mode_s1)))
		else $error("requested mode not entered");

	// The fault flag is only set by a heat tick.
	a_fault_from_heat: assert property (@(posedge clk) disable iff (!arst_n)
		(!fault_q && process && (mode_s1 != MODE_HEAT)) |=> !fault_q)
		else $error("fault flag set outside heat mode");

	// A result is only produced from a held input item.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s2 && !valid_s1) |=> !valid_s2)
		else $error("result appeared without an input item");

endmodule

`default_nettype wire
